// ===== rtl/core/frame_ring_drop_oldest_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the frame ring
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef FRAME_RING_DROP_OLDEST_ASSERT_SVH
`define FRAME_RING_DROP_OLDEST_ASSERT_SVH

`ifndef SYNTH

// Condition that must hold at every clock edge outside reset.
`define FRDO_ASSERT(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define FRDO_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define FRDO_ASSERT(lbl, clk, rst, cond, msg)
`define FRDO_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/core/frdo_pkg.sv =====
// ----------------------------------------------------------------------------
// frdo_pkg
// Opcodes, status codes, state encoding and stream widths of the frame ring.
// ----------------------------------------------------------------------------
`default_nettype none

package frdo_pkg;

  localparam int FRAME_BYTES_DEF = 64;
  localparam int RING_SLOTS_DEF  = 32;

  localparam int WORDS_PER_SLOT = 8;
  localparam int WSEL_W         = 3;
  localparam int WORD_W         = 64;
  localparam int LEN_W          = 7;
  localparam int AMT_W          = 6;

  localparam int IN_DATA_W  = 560;
  localparam int OUT_DATA_W = 536;

  localparam logic [2:0] OP_CONNECT    = 3'd0;
  localparam logic [2:0] OP_DISCONNECT = 3'd1;
  localparam logic [2:0] OP_SEND       = 3'd2;
  localparam logic [2:0] OP_RECEIVE    = 3'd3;
  localparam logic [2:0] OP_INJECT     = 3'd4;
  localparam logic [2:0] OP_RESET      = 3'd5;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_LOSS    = 3'd1;
  localparam logic [2:0] ST_DOWN    = 3'd2;
  localparam logic [2:0] ST_INVAL   = 3'd3;
  localparam logic [2:0] ST_TIMEOUT = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WRITE,
    S_READ,
    S_DONE
  } state_t;

  // Byte mask of word w: keep bytes whose frame offset lies below len.
  function automatic logic [WORD_W-1:0] keep_mask(input logic [WSEL_W-1:0] w,
                                                  input logic [LEN_W-1:0] len);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if ({1'b0, w, 3'(b)} < len) begin
        m[8*b +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/frdo_ram.sv =====
// ----------------------------------------------------------------------------
// frdo_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module frdo_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/frame_ring_drop_oldest.sv =====
// ----------------------------------------------------------------------------
// frame_ring_drop_oldest
// Ring of frame slots in a word-wide payload RAM; a send into a full ring
// overwrites the oldest frame and reports the loss.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                        | tuser
//  s_*     | in  | frame_length, receive_capacity, loss_count,| opcode
//          |     | payload_word_0..7                          |
//  m_*     | out | received_length, loss_amount,              | status
//          |     | pending_frames, read_word_0..7, zero pad   |
//
//  Connect, disconnect, reset, inject loss and rejected requests pass from
//  the execute step straight to the done step; a stored send first writes the
//  frame words and a popped receive first reads them back. The payload RAM
//  moves one 64-bit word per cycle, its read data trailing the address. A new
//  request is taken only once the previous result is loaded.
//  Reset empties the ring and drops the link; no clearing pass is needed, as
//  only slots written since the last clear are ever read.
//  A result waits in the output register; the next request is accepted and
//  worked on meanwhile, and holds in its last step until that register frees.
// ----------------------------------------------------------------------------
`default_nettype none

`include "frame_ring_drop_oldest_assert.svh"

module frame_ring_drop_oldest
  import frdo_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF,
  parameter int RING_SLOTS  = RING_SLOTS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output      logic                  s_tready,
  // frame_length[15:0], receive_capacity[31:16], loss_count[47:32],
  // payload_word_0..7 at [48+64w +: 64]
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // opcode[2:0]
  input  wire logic [2:0]            s_tuser,
  output      logic                  m_tvalid,
  input  wire logic                  m_tready,
  // received_length[6:0], loss_amount[12:7], pending_frames[18:13],
  // read_word_0..7 at [19+64w +: 64], zeros [535:531]
  output      logic [OUT_DATA_W-1:0] m_tdata,
  // status[2:0]
  output      logic [2:0]            m_tuser
);

  localparam int IW  = $clog2(RING_SLOTS);
  localparam int CW  = $clog2(RING_SLOTS + 1);
  localparam int PAW = IW + WSEL_W;

  state_t state, state_next;

  logic [2:0]        op_q;
  logic [15:0]       len_q;
  logic [15:0]       cap_q;
  logic [15:0]       lcnt_q;
  logic [WORD_W-1:0] words [WORDS_PER_SLOT];
  logic [WSEL_W:0]   cnt;

  logic          link_up;
  logic [IW-1:0] wr_idx;
  logic [IW-1:0] rd_idx;
  logic [CW-1:0] count;
  logic [IW-1:0] wslot;
  logic [IW-1:0] rslot;

  logic [2:0]       res_status;
  logic [LEN_W-1:0] res_rlen;
  logic [AMT_W-1:0] res_loss;
  logic [AMT_W-1:0] res_pend;
  logic             rd_ok;

  // RAM ports
  logic             len_we;
  logic [LEN_W-1:0] len_rdata;
  logic             pay_we;
  logic [PAW-1:0]   pay_waddr;
  logic [PAW-1:0]   pay_raddr;
  logic [WORD_W-1:0] pay_wdata;
  logic [WORD_W-1:0] pay_rdata;

  // execute-step decisions
  logic             link_n;
  logic [IW-1:0]    wr_n;
  logic [IW-1:0]    rd_n;
  logic [CW-1:0]    count_n;
  logic [2:0]       st_n;
  logic [AMT_W-1:0] loss_n;
  logic [LEN_W-1:0] rlen_n;
  logic             go_write;
  logic             go_read;
  logic [IW-1:0]    wr_inc;
  logic [IW-1:0]    rd_inc;
  logic [CW-1:0]    drop_n;
  logic [CW:0]      rd_sum;
  logic [IW-1:0]    rd_skip;

  logic                  out_free;
  logic [OUT_DATA_W-1:0] out_data;

  // Slot lengths: read always at the oldest slot, written at the send slot.
  frdo_ram #(
    .WIDTH(LEN_W),
    .DEPTH(RING_SLOTS)
  ) u_len_ram (
    .clk  (clk),
    .we   (len_we),
    .waddr(wr_idx),
    .wdata(len_q[LEN_W-1:0]),
    .raddr(rd_idx),
    .rdata(len_rdata)
  );

  frdo_ram #(
    .WIDTH(WORD_W),
    .DEPTH(RING_SLOTS * WORDS_PER_SLOT)
  ) u_pay_ram (
    .clk  (clk),
    .we   (pay_we),
    .waddr(pay_waddr),
    .wdata(pay_wdata),
    .raddr(pay_raddr),
    .rdata(pay_rdata)
  );

  assign out_free = !m_tvalid || m_tready;

  assign wr_inc = (wr_idx == IW'(RING_SLOTS - 1)) ? '0 : wr_idx + 1'b1;
  assign rd_inc = (rd_idx == IW'(RING_SLOTS - 1)) ? '0 : rd_idx + 1'b1;

  // inject loss: drop min(loss_count, count) oldest frames
  assign drop_n  = (16'(count) < lcnt_q) ? count : lcnt_q[CW-1:0];
  assign rd_sum  = (CW + 1)'(rd_idx) + (CW + 1)'(drop_n);
  assign rd_skip = (rd_sum >= (CW + 1)'(RING_SLOTS)) ?
                   IW'(rd_sum - (CW + 1)'(RING_SLOTS)) : IW'(rd_sum);

  // The span from the oldest slot holds exactly count written frames, so the
  // oldest slot is always valid when count is nonzero.
  always_comb begin
    link_n   = link_up;
    wr_n     = wr_idx;
    rd_n     = rd_idx;
    count_n  = count;
    st_n     = ST_OK;
    loss_n   = '0;
    rlen_n   = '0;
    go_write = 1'b0;
    go_read  = 1'b0;
    unique case (op_q)
      OP_CONNECT: begin
        link_n  = 1'b1;
        wr_n    = '0;
        rd_n    = '0;
        count_n = '0;
      end
      OP_DISCONNECT: begin
        link_n = 1'b0;
      end
      OP_SEND: begin
        if (!link_up) begin
          st_n = ST_DOWN;
        end else if (len_q > 16'(FRAME_BYTES)) begin
          st_n = ST_INVAL;
        end else begin
          go_write = 1'b1;
          wr_n     = wr_inc;
          if (count == CW'(RING_SLOTS)) begin
            rd_n   = rd_inc;
            st_n   = ST_LOSS;
            loss_n = AMT_W'(1);
          end else begin
            count_n = count + 1'b1;
          end
        end
      end
      OP_RECEIVE: begin
        if (!link_up) begin
          st_n = ST_DOWN;
        end else if (count == '0) begin
          st_n = ST_TIMEOUT;
        end else if (cap_q < 16'(len_rdata)) begin
          st_n = ST_INVAL;
        end else begin
          go_read = 1'b1;
          rlen_n  = len_rdata;
          rd_n    = rd_inc;
          count_n = count - 1'b1;
        end
      end
      OP_INJECT: begin
        if (lcnt_q != '0) begin
          st_n    = ST_LOSS;
          loss_n  = AMT_W'(drop_n);
          rd_n    = rd_skip;
          count_n = count - drop_n;
        end
      end
      OP_RESET: begin
        link_n  = 1'b0;
        wr_n    = '0;
        rd_n    = '0;
        count_n = '0;
      end
      default: begin
        st_n = ST_INVAL;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (go_write) begin
          state_next = S_WRITE;
        end else if (go_read) begin
          state_next = S_READ;
        end else begin
          state_next = S_DONE;
        end
      end
      S_WRITE: begin
        if (cnt[WSEL_W-1:0] == WSEL_W'(WORDS_PER_SLOT - 1)) state_next = S_DONE;
      end
      S_READ: begin
        if (cnt == (WSEL_W + 1)'(WORDS_PER_SLOT)) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = (state == S_IDLE);
    len_we    = (state == S_EXEC) && go_write;
    pay_we    = (state == S_WRITE);
    pay_waddr = {wslot, cnt[WSEL_W-1:0]};
    pay_wdata = words[cnt[WSEL_W-1:0]] &
                keep_mask(cnt[WSEL_W-1:0], len_q[LEN_W-1:0]);
    pay_raddr = {rslot, cnt[WSEL_W-1:0]};
  end

  always_comb begin
    out_data = '0;
    out_data[LEN_W-1:0]                = res_rlen;
    out_data[LEN_W +: AMT_W]           = res_loss;
    out_data[LEN_W + AMT_W +: AMT_W]   = res_pend;
    for (int w = 0; w < WORDS_PER_SLOT; w++) begin
      out_data[LEN_W + 2*AMT_W + WORD_W*w +: WORD_W] = rd_ok ? words[w] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      link_up  <= 1'b0;
      wr_idx   <= '0;
      rd_idx   <= '0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_EXEC) begin
        link_up <= link_n;
        wr_idx  <= wr_n;
        rd_idx  <= rd_n;
        count   <= count_n;
      end
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // request capture, frame word moves, result build
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          op_q   <= s_tuser;
          len_q  <= s_tdata[15:0];
          cap_q  <= s_tdata[31:16];
          lcnt_q <= s_tdata[47:32];
          for (int w = 0; w < WORDS_PER_SLOT; w++) begin
            words[w] <= s_tdata[48 + WORD_W*w +: WORD_W];
          end
        end
      end
      S_EXEC: begin
        cnt        <= '0;
        wslot      <= wr_idx;
        rslot      <= rd_idx;
        res_status <= st_n;
        res_rlen   <= rlen_n;
        res_loss   <= loss_n;
        res_pend   <= AMT_W'(count_n);
        rd_ok      <= go_read;
      end
      S_WRITE: begin
        cnt <= cnt + 1'b1;
      end
      S_READ: begin
        cnt <= cnt + 1'b1;
        // read data arrives in the cycle after its address
        if (cnt != '0) begin
          words[WSEL_W'(cnt - 1'b1)] <= pay_rdata;
        end
      end
      S_DONE: begin
        if (out_free) begin
          m_tdata <= out_data;
          m_tuser <= res_status;
        end
      end
      default: ;
    endcase
  end

  `FRDO_ASSERT(a_count_bound, clk, rst, count <= CW'(RING_SLOTS),
               "frame count beyond ring size")
  `FRDO_ASSERT(a_full_aligned, clk, rst,
               (count != CW'(RING_SLOTS)) || (wr_idx == rd_idx),
               "full ring with write and read pointers apart")
  `FRDO_ASSERT_NEXT(a_reset_op, clk, rst, (state == S_EXEC) && (op_q == OP_RESET),
                    (count == '0) && !link_up, "reset request left ring or link state")
  `FRDO_ASSERT(a_rlen_ok_only, clk, rst,
               !m_tvalid || (m_tuser == ST_OK) || (m_tdata[LEN_W-1:0] == '0),
               "received length on a failed result")

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for frame_ring_drop_oldest. Directed corner requests
// come first, then random link sessions of sends, receives and loss
// injection. Both stream ports stall at random. Each result is checked
// field by field against a shadow copy of the ring.
// ----------------------------------------------------------------------------
module testbench;
  import frdo_pkg::*;

  localparam logic [2:0] OP_SPARE_6   = 3'd6;
  localparam logic [2:0] OP_SPARE_7   = 3'd7;
  localparam logic [2:0] ST_FRAME_ERR = 3'd5;

  localparam int RANDOM_ITEMS = 1400;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 400;
  localparam int END_CYCLES   = 40;

  // Same layout as s_tdata: length lowest, payload words on top.
  typedef struct packed {
    logic [WORDS_PER_SLOT-1:0][WORD_W-1:0] payload;
    logic [15:0]                           loss_count;
    logic [15:0]                           capacity;
    logic [15:0]                           length;
  } req_body_t;

  typedef struct packed {
    logic [2:0] opcode;
    req_body_t  body;
  } ring_req_t;

  // Same layout as m_tdata.
  typedef struct packed {
    logic [OUT_DATA_W-19-WORDS_PER_SLOT*WORD_W-1:0] pad;
    logic [WORDS_PER_SLOT-1:0][WORD_W-1:0]           words;
    logic [AMT_W-1:0]                                pending;
    logic [AMT_W-1:0]                                loss;
    logic [LEN_W-1:0]                                length;
  } reply_body_t;

  typedef struct packed {
    logic [2:0]  status;
    reply_body_t body;
  } ring_reply_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic [2:0]            s_tuser  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [2:0]            m_tuser;

  frame_ring_drop_oldest dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Shadow ring
  logic [WORD_W-1:0] shadow_words [RING_SLOTS_DEF*WORDS_PER_SLOT];
  logic [LEN_W-1:0]  shadow_len   [RING_SLOTS_DEF];
  bit                shadow_used  [RING_SLOTS_DEF];
  int unsigned       shadow_wr, shadow_rd, shadow_held;
  bit                link_is_up;

  ring_req_t   pending_reqs[$];
  ring_reply_t expected_replies[$];
  ring_req_t   offered_req;
  int unsigned accepted_reqs, total_reqs, error_count, cycle_count;
  int unsigned hold_left;
  bit          hold_done;

  function automatic void shadow_clear();
    for (int i = 0; i < RING_SLOTS_DEF; i++) begin
      shadow_len[i]  = '0;
      shadow_used[i] = 1'b0;
    end
    shadow_wr   = 0;
    shadow_rd   = 0;
    shadow_held = 0;
  endfunction

  function automatic void shadow_drop_oldest();
    shadow_used[shadow_rd] = 1'b0;
    shadow_len[shadow_rd]  = '0;
    shadow_rd   = (shadow_rd + 1) % RING_SLOTS_DEF;
    shadow_held = shadow_held - 1;
  endfunction

  // Zero the bytes of word w at or past frame offset len.
  function automatic logic [WORD_W-1:0] trim_word(logic [WORD_W-1:0] word, int unsigned w,
                                                  int unsigned len);
    int unsigned lo;
    lo = 8 * w;
    if (len <= lo) return '0;
    if (len - lo >= 8) return word;
    return word & ((64'd1 << (8 * (len - lo))) - 64'd1);
  endfunction

  function automatic ring_reply_t predict_reply(ring_req_t r);
    ring_reply_t y;
    int unsigned n, base;
    y = '0;
    y.status = ST_OK;
    case (r.opcode)
      OP_CONNECT: begin
        shadow_clear();
        link_is_up = 1'b1;
      end
      OP_DISCONNECT: link_is_up = 1'b0;
      OP_SEND: begin
        if (!link_is_up) begin
          y.status = ST_DOWN;
        end else if (r.body.length > FRAME_BYTES_DEF) begin
          y.status = ST_INVAL;
        end else begin
          if (shadow_held >= RING_SLOTS_DEF) begin
            // full ring: oldest frame gives way
            shadow_used[shadow_rd] = 1'b0;
            shadow_rd   = (shadow_rd + 1) % RING_SLOTS_DEF;
            shadow_held = shadow_held - 1;
            y.status    = ST_LOSS;
            y.body.loss = AMT_W'(1);
          end
          base = shadow_wr * WORDS_PER_SLOT;
          for (int w = 0; w < WORDS_PER_SLOT; w++) begin
            shadow_words[base + w] = trim_word(r.body.payload[w], w, 32'(r.body.length));
          end
          shadow_len[shadow_wr]  = r.body.length[LEN_W-1:0];
          shadow_used[shadow_wr] = 1'b1;
          shadow_wr   = (shadow_wr + 1) % RING_SLOTS_DEF;
          shadow_held = shadow_held + 1;
        end
      end
      OP_RECEIVE: begin
        if (!link_is_up) begin
          y.status = ST_DOWN;
        end else if (shadow_held == 0) begin
          y.status = ST_TIMEOUT;
        end else if (!shadow_used[shadow_rd]) begin
          shadow_held = 0;
          y.status    = ST_FRAME_ERR;
        end else if (r.body.capacity < 16'(shadow_len[shadow_rd])) begin
          y.status = ST_INVAL;
        end else begin
          y.body.length = shadow_len[shadow_rd];
          base = shadow_rd * WORDS_PER_SLOT;
          for (int w = 0; w < WORDS_PER_SLOT; w++) begin
            y.body.words[w] = trim_word(shadow_words[base + w], w,
                                        32'(shadow_len[shadow_rd]));
          end
          shadow_drop_oldest();
        end
      end
      OP_INJECT: begin
        if (r.body.loss_count != 0) begin
          n = (32'(r.body.loss_count) > shadow_held) ? shadow_held :
              32'(r.body.loss_count);
          for (int i = 0; i < n; i++) shadow_drop_oldest();
          y.status    = ST_LOSS;
          y.body.loss = AMT_W'(n);
        end
      end
      OP_RESET: begin
        shadow_clear();
        link_is_up = 1'b0;
      end
      default: y.status = ST_INVAL;
    endcase
    y.body.pending = AMT_W'(shadow_held);
    return y;
  endfunction

  function automatic ring_req_t make_req(logic [2:0] op, logic [15:0] len, logic [15:0] cap,
                                         logic [15:0] lcnt);
    ring_req_t r;
    r.opcode          = op;
    r.body.length     = len;
    r.body.capacity   = cap;
    r.body.loss_count = lcnt;
    for (int w = 0; w < WORDS_PER_SLOT; w++) r.body.payload[w] = {$urandom, $urandom};
    return r;
  endfunction

  // Mostly sensible field values, with the odd full-range one.
  function automatic ring_req_t shaped_req(logic [2:0] op);
    ring_req_t   r;
    int unsigned sel;
    r   = make_req(op, 16'($urandom), 16'($urandom), 16'($urandom));
    sel = $urandom_range(19);
    case (op)
      OP_SEND: begin
        if (sel == 1) r.body.length = 16'(FRAME_BYTES_DEF + 1);
        else if (sel == 2) r.body.length = 16'(FRAME_BYTES_DEF);
        else if (sel == 3) r.body.length = '0;
        else if (sel > 3) r.body.length = 16'($urandom_range(FRAME_BYTES_DEF));
      end
      OP_RECEIVE: begin
        if (sel == 1) r.body.capacity = '0;
        else if (sel > 1 && sel < 6) r.body.capacity = 16'($urandom_range(FRAME_BYTES_DEF));
        else if (sel >= 6) r.body.capacity = 16'(FRAME_BYTES_DEF + $urandom_range(3));
      end
      OP_INJECT: begin
        if (sel == 1) r.body.loss_count = '0;
        else if (sel == 2) r.body.loss_count = 16'(RING_SLOTS_DEF + 1);
        else if (sel > 2) r.body.loss_count = 16'(1 + $urandom_range(3));
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] pick_op();
    int unsigned x;
    x = $urandom_range(99);
    if (x < 45) return OP_SEND;
    if (x < 80) return OP_RECEIVE;
    if (x < 88) return OP_INJECT;
    if (x < 91) return OP_CONNECT;
    if (x < 94) return OP_DISCONNECT;
    if (x < 97) return OP_RESET;
    return x[0] ? OP_SPARE_7 : OP_SPARE_6;
  endfunction

  function automatic int unsigned idle_pct(bit receiver);
    if (accepted_reqs < total_reqs / 3) return receiver ? 65 : 33;
    if (accepted_reqs < 2 * total_reqs / 3) return receiver ? 33 : 65;
    return 0;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
      error_count++;
    end
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Request driver
  always @(posedge clk) begin : driver
    bit offer;
    if (rst) begin
      s_tvalid <= 1'b0;
      shadow_clear();
      link_is_up    = 1'b0;
      accepted_reqs = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_replies.push_back(predict_reply(offered_req));
        accepted_reqs++;
      end
      if (!s_tvalid || s_tready) begin
        // one pause midway until the ring has answered everything
        offer = pending_reqs.size() != 0 &&
                !(accepted_reqs == total_reqs / 2 && expected_replies.size() != 0) &&
                $urandom_range(99) >= idle_pct(1'b0);
        if (offer) begin
          offered_req = pending_reqs.pop_front();
          s_tdata <= offered_req.body;
          s_tuser <= offered_req.opcode;
        end
        s_tvalid <= offer;
      end
    end
  end

  // Result monitor and receiver stalls
  always @(posedge clk) begin : monitor
    ring_reply_t want, got;
    if (rst) begin
      m_tready <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = {m_tuser, m_tdata};
        if (expected_replies.size() == 0) begin
          $display("%0t unexpected result: expected none, actual %h", $time, got);
          error_count++;
        end else begin
          want = expected_replies.pop_front();
          check_field("status", 64'(want.status), 64'(got.status));
          check_field("received_length", 64'(want.body.length), 64'(got.body.length));
          check_field("loss_amount", 64'(want.body.loss), 64'(got.body.loss));
          check_field("pending_frames", 64'(want.body.pending), 64'(got.body.pending));
          check_field("pad", 64'(want.body.pad), 64'(got.body.pad));
          for (int w = 0; w < WORDS_PER_SLOT; w++) begin
            check_field($sformatf("read_word_%0d", w), want.body.words[w], got.body.words[w]);
          end
        end
      end
      // long hold-off late in the run so the input side backs up
      if (!hold_done && accepted_reqs >= 5 * total_reqs / 6) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= $urandom_range(99) >= idle_pct(1'b1);
      end
    end
  end

  initial begin : stimulus
    ring_req_t   r;
    int unsigned kind, n, sel, directed;
    bit          first_session;

    // directed corners: dead link, empty ring, length and capacity limits
    pending_reqs.push_back(make_req(OP_RECEIVE, 16'($urandom), 16'hFFFF, 16'($urandom)));
    pending_reqs.push_back(make_req(OP_SEND, 16'd8, 16'($urandom), 16'($urandom)));
    pending_reqs.push_back(make_req(OP_INJECT, 16'($urandom), 16'($urandom), 16'd0));
    pending_reqs.push_back(make_req(OP_INJECT, 16'($urandom), 16'($urandom), 16'hFFFF));
    pending_reqs.push_back(make_req(OP_CONNECT, 16'($urandom), 16'($urandom), 16'($urandom)));
    pending_reqs.push_back(make_req(OP_RECEIVE, 16'($urandom), 16'hFFFF, 16'($urandom)));
    pending_reqs.push_back(make_req(OP_SEND, 16'd0, 16'($urandom), 16'($urandom)));
    r = make_req(OP_SEND, 16'd64, 16'($urandom), 16'($urandom));
    r.body.payload = '1;
    pending_reqs.push_back(r);
    pending_reqs.push_back(make_req(OP_SEND, 16'd65, 16'($urandom), 16'($urandom)));
    pending_reqs.push_back(make_req(OP_SEND, 16'hFFFF, 16'($urandom), 16'($urandom)));
    pending_reqs.push_back(make_req(OP_SEND, 16'd13, 16'($urandom), 16'($urandom)));
    pending_reqs.push_back(make_req(OP_RECEIVE, 16'($urandom), 16'd0, 16'($urandom)));
    pending_reqs.push_back(make_req(OP_RECEIVE, 16'($urandom), 16'd63, 16'($urandom)));
    pending_reqs.push_back(make_req(OP_RECEIVE, 16'($urandom), 16'hFFFF, 16'($urandom)));
    pending_reqs.push_back(make_req(OP_RECEIVE, 16'($urandom), 16'd12, 16'($urandom)));
    pending_reqs.push_back(make_req(OP_RECEIVE, 16'($urandom), 16'd13, 16'($urandom)));
    pending_reqs.push_back(make_req(OP_SPARE_6, 16'($urandom), 16'($urandom), 16'($urandom)));
    pending_reqs.push_back(make_req(OP_SPARE_7, 16'($urandom), 16'($urandom), 16'($urandom)));
    pending_reqs.push_back(make_req(OP_SEND, 16'd40, 16'($urandom), 16'($urandom)));
    pending_reqs.push_back(make_req(OP_SEND, 16'd1, 16'($urandom), 16'($urandom)));
    pending_reqs.push_back(make_req(OP_INJECT, 16'($urandom), 16'($urandom), 16'd1));
    pending_reqs.push_back(make_req(OP_DISCONNECT, 16'($urandom), 16'($urandom), 16'($urandom)));
    pending_reqs.push_back(make_req(OP_SEND, 16'd4, 16'($urandom), 16'($urandom)));
    pending_reqs.push_back(make_req(OP_RECEIVE, 16'($urandom), 16'hFFFF, 16'($urandom)));
    pending_reqs.push_back(make_req(OP_RESET, 16'($urandom), 16'($urandom), 16'($urandom)));
    pending_reqs.push_back(make_req(OP_INJECT, 16'($urandom), 16'($urandom), 16'd5));
    directed = pending_reqs.size();

    // random sessions, each opened by a connect
    first_session = 1'b1;
    while (pending_reqs.size() < directed + RANDOM_ITEMS) begin
      pending_reqs.push_back(make_req(OP_CONNECT, 16'($urandom), 16'($urandom),
                                      16'($urandom)));
      kind = first_session ? 0 : $urandom_range(9);
      if (kind < 3) begin
        // overfill so the oldest frames get overwritten, then drain part
        n = first_session ? RING_SLOTS_DEF + 12 : RING_SLOTS_DEF + $urandom_range(12);
        repeat (n) begin
          pending_reqs.push_back(make_req(OP_SEND, 16'($urandom_range(FRAME_BYTES_DEF)),
                                          16'($urandom), 16'($urandom)));
        end
        n = $urandom_range(RING_SLOTS_DEF + 4);
        repeat (n) pending_reqs.push_back(shaped_req(OP_RECEIVE));
      end else begin
        n = 10 + $urandom_range(40);
        repeat (n) pending_reqs.push_back(shaped_req(pick_op()));
      end
      first_session = 1'b0;
      sel = $urandom_range(9);
      if (sel < 4) begin
        pending_reqs.push_back(make_req(OP_DISCONNECT, 16'($urandom), 16'($urandom),
                                        16'($urandom)));
      end else if (sel < 6) begin
        pending_reqs.push_back(make_req(OP_RESET, 16'($urandom), 16'($urandom),
                                        16'($urandom)));
      end
      n = $urandom_range(3);
      repeat (n) pending_reqs.push_back(shaped_req(pick_op()));
    end
    total_reqs = pending_reqs.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (pending_reqs.size() != 0 || s_tvalid || expected_replies.size() != 0);
    repeat (END_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
